@@ design/pct_pkg.sv @@
package pct_pkg;

    localparam int OPERATION_W = 2;
    localparam int BUTTON_W    = 3;
    localparam int TIME_W      = 11;
    localparam int LIMIT_W     = 16;
    localparam int IDLE_W      = 17;
    localparam int CHOSEN_W    = 2;
    localparam int LED_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OPERATION_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPERATION_W-1:0] OP_SLEEP  = 2'd1;
    localparam logic [OPERATION_W-1:0] OP_BUTTON = 2'd2;

    localparam logic [BUTTON_W-1:0] BTN_RELEASED = 3'd0;
    localparam logic [BUTTON_W-1:0] BTN_UP       = 3'd1;
    localparam logic [BUTTON_W-1:0] BTN_DOWN     = 3'd2;
    localparam logic [BUTTON_W-1:0] BTN_LEFT     = 3'd3;
    localparam logic [BUTTON_W-1:0] BTN_RIGHT    = 3'd4;
    localparam logic [BUTTON_W-1:0] BTN_START    = 3'd5;

    localparam logic [LED_W-1:0] LED_OFF    = 2'd0;
    localparam logic [LED_W-1:0] LED_STEADY = 2'd1;
    localparam logic [LED_W-1:0] LED_BLINK  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_FLOOR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_CEILING = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT     = 2'd2;

    localparam logic [TIME_W-1:0]  RESET_PRESET  = 11'd64;
    localparam logic [TIME_W-1:0]  RESET_FLOOR   = 11'd4;
    localparam logic [TIME_W-1:0]  RESET_CEILING = 11'd1596;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT   = 16'd60;
    localparam logic [TIME_W+1:0]  STEP_SIZE     = 13'd4;

    typedef struct packed {
        logic                motor_on;
        logic                is_asleep;
        logic [CHOSEN_W-1:0] chosen_slot;
        logic [TIME_W-1:0]   remaining;
        logic [TIME_W-1:0]   slot_value;
        logic [LED_W-1:0]    led_mode;
    } result_t;

endpackage

@@ design/pct_core.sv @@
module pct_core
    import pct_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   fire,
    input  logic [OPERATION_W-1:0] operation,
    input  logic [BUTTON_W-1:0]    button,
    output result_t                result
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int SEL_W  = (SLOT_W < CHOSEN_W) ? CHOSEN_W : SLOT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    logic [TIME_W-1:0]  floor_reg;
    logic [TIME_W-1:0]  ceiling_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [TIME_W-1:0] preset_reg [NUM_SLOTS];
    logic [TIME_W-1:0] preset_next [NUM_SLOTS];
    logic [SLOT_W-1:0] sel_reg;
    logic [SLOT_W-1:0] sel_next;
    logic [TIME_W-1:0] countdown_reg;
    logic [TIME_W-1:0] countdown_next;
    logic [IDLE_W-1:0] idle_reg;
    logic [IDLE_W-1:0] idle_next;
    logic              asleep_reg;
    logic              asleep_next;
    logic              grinding_reg;
    logic              grinding_next;

    logic [TIME_W-1:0] cur_preset;
    logic [IDLE_W-1:0] idle_inc;
    logic [TIME_W+1:0] adj_sum;
    logic [TIME_W+1:0] adj_clip;
    logic [TIME_W-1:0] adj_value;
    logic [SLOT_W-1:0] sel_left;
    logic [SLOT_W-1:0] sel_right;
    logic              pressed;
    logic [SEL_W-1:0]  sel_wide;

    assign cur_preset = preset_reg[sel_reg];
    assign idle_inc   = idle_reg + IDLE_W'(1);
    assign pressed    = (button != BTN_RELEASED);
    assign sel_right  = (sel_reg == LAST_SLOT) ? '0 : sel_reg + SLOT_W'(1);
    assign sel_left   = (sel_reg == '0) ? LAST_SLOT : sel_reg - SLOT_W'(1);

    // preset step with ceiling clamp first, floor wins
    always_comb
    begin
        if (button == BTN_UP)
        begin
            adj_sum = {2'b00, cur_preset} + STEP_SIZE;
        end
        else
        begin
            adj_sum = {2'b00, cur_preset} - STEP_SIZE;
        end
        adj_clip = adj_sum;
        if ($signed(adj_clip) > $signed({2'b00, ceiling_reg}))
        begin
            adj_clip = {2'b00, ceiling_reg};
        end
        if ($signed(adj_clip) < $signed({2'b00, floor_reg}))
        begin
            adj_clip = {2'b00, floor_reg};
        end
        adj_value = adj_clip[TIME_W-1:0];
    end

    always_comb
    begin
        preset_next    = preset_reg;
        sel_next       = sel_reg;
        countdown_next = countdown_reg;
        idle_next      = idle_reg;
        asleep_next    = asleep_reg;
        grinding_next  = grinding_reg;
        case (operation)
            OP_TICK:
            begin
                if (grinding_reg)
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - TIME_W'(1);
                    end
                    else
                    begin
                        grinding_next  = 1'b0;
                        countdown_next = cur_preset;
                        asleep_next    = 1'b0;
                        idle_next      = '0;
                    end
                end
            end
            OP_SLEEP:
            begin
                if (!asleep_reg)
                begin
                    if (idle_inc > {1'b0, limit_reg})
                    begin
                        asleep_next = 1'b1;
                        idle_next   = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            OP_BUTTON:
            begin
                if (grinding_reg && pressed)
                begin
                    grinding_next  = 1'b0;
                    countdown_next = cur_preset;
                    asleep_next    = 1'b0;
                    idle_next      = '0;
                end
                else if (asleep_reg && pressed)
                begin
                    asleep_next = 1'b0;
                    idle_next   = '0;
                end
                else if (!grinding_reg)
                begin
                    idle_next = '0;
                    case (button)
                        BTN_UP, BTN_DOWN:
                        begin
                            preset_next[sel_reg] = adj_value;
                            countdown_next       = adj_value;
                        end
                        BTN_LEFT:
                        begin
                            sel_next       = sel_left;
                            countdown_next = preset_reg[sel_left];
                        end
                        BTN_RIGHT:
                        begin
                            sel_next       = sel_right;
                            countdown_next = preset_reg[sel_right];
                        end
                        BTN_START:
                        begin
                            grinding_next = 1'b1;
                            asleep_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sel_wide = SEL_W'(sel_next);

    always_comb
    begin
        result.motor_on    = grinding_next;
        result.is_asleep   = asleep_next;
        result.chosen_slot = sel_wide[CHOSEN_W-1:0];
        result.remaining   = countdown_next;
        result.slot_value  = preset_next[sel_next];
        if (grinding_next)
        begin
            result.led_mode = LED_OFF;
        end
        else if (asleep_next)
        begin
            result.led_mode = LED_BLINK;
        end
        else
        begin
            result.led_mode = LED_STEADY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= RESET_FLOOR;
            ceiling_reg <= RESET_CEILING;
            limit_reg   <= RESET_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PRESET_FLOOR:   floor_reg   <= cfg_data[TIME_W-1:0];
                CFG_PRESET_CEILING: ceiling_reg <= cfg_data[TIME_W-1:0];
                CFG_IDLE_LIMIT:     limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                preset_reg[i] <= RESET_PRESET;
            end
            sel_reg       <= '0;
            countdown_reg <= RESET_PRESET;
            idle_reg      <= '0;
            asleep_reg    <= 1'b0;
            grinding_reg  <= 1'b0;
        end
        else if (fire)
        begin
            preset_reg    <= preset_next;
            sel_reg       <= sel_next;
            countdown_reg <= countdown_next;
            idle_reg      <= idle_next;
            asleep_reg    <= asleep_next;
            grinding_reg  <= grinding_next;
        end
    end

    // countdown only moves while grinding or on selection/preset changes
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && operation == OP_TICK && !grinding_reg) |=> $stable(countdown_reg))
        else $error("countdown changed on a tick while stopped");

    a_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(grinding_reg) |-> $past(fire && operation == OP_BUTTON && button == BTN_START))
        else $error("motor started without start button");

    a_sleep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(asleep_reg) |-> (idle_reg == '0))
        else $error("idle count not cleared on sleep entry");

endmodule

@@ design/pct_obuf.sv @@
module pct_obuf
    import pct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item ahead of the output register");

endmodule

@@ design/preset_countdown_timer_controller.sv @@
// an accepted item's result is formed combinationally and registered in the output buffer
// throughput: one item per cycle while in_stall is low; state update is a single registered pass
// a two-entry output buffer keeps input taking items while one result waits
// in_stall rises only when both output entries are full
// reset: asynchronous active low; presets and countdown load 64, config loads defaults
module preset_countdown_timer_controller
    import pct_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [OPERATION_W-1:0] operation,
    input  logic [BUTTON_W-1:0]    button,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   motor_on,
    output logic                   is_asleep,
    output logic [CHOSEN_W-1:0]    chosen_slot,
    output logic [TIME_W-1:0]      remaining,
    output logic [TIME_W-1:0]      slot_value,
    output logic [LED_W-1:0]       led_mode
);

    logic    fire;
    logic    full;
    result_t result;
    result_t out_data;

    assign in_stall = full;
    assign fire     = in_valid && !full;

    pct_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .operation (operation),
        .button    (button),
        .result    (result)
    );

    pct_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign motor_on    = out_data.motor_on;
    assign is_asleep   = out_data.is_asleep;
    assign chosen_slot = out_data.chosen_slot;
    assign remaining   = out_data.remaining;
    assign slot_value  = out_data.slot_value;
    assign led_mode    = out_data.led_mode;

endmodule
